// ----- sv/lal_pkg.sv -----
// shared types, constants and the arctangent table of the look-at angle limiter
`timescale 1ns / 1ps
`default_nettype none

package lal_pkg;

    localparam int CORDIC_STAGES_DEF = 16;

    localparam int IN_W       = 32;
    localparam int ANG_W      = 16;
    localparam int LIM_W      = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_LIMIT   = 2'd1;
    localparam logic [LIM_W-1:0]     LIMIT_RST       = 15'd12868;

    // prescaled component, magnitude below 2^30
    localparam int PRE_W          = 31;
    localparam int PRE_LIMIT_BIT  = 30;
    localparam int VEC_W          = 2 * PRE_W;
    localparam int MAG_W          = VEC_W - 1;
    localparam int PRESCALE_STEPS = MAG_W - PRE_LIMIT_BIT;
    localparam int SQRT_CELLS     = 31;

    localparam int CX_W       = 34;
    localparam int Z_W        = 33;
    localparam int ROUND_SH   = 16;
    localparam int ROUND_HALF = 1 << (ROUND_SH - 1);

    localparam logic signed [Z_W-1:0]   ANG_HALF_PI = 33'sd843314857;
    localparam logic signed [ANG_W-1:0] Q13_PI      = 16'sd25736;

    typedef struct packed {
        logic [VEC_W-1:0] rem;
        logic [VEC_W-1:0] root;
    } t_sqrt;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic;

    typedef struct packed {
        logic             sy;
        logic             sx;
        logic [MAG_W-1:0] my;
        logic [MAG_W-1:0] mx;
    } t_smag;

    // atan(2^-i) in units of 2^-29 rad
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] idx);
        logic [30:0] v;
        case (idx)
            5'd0:    v = 31'd421657428;
            5'd1:    v = 31'd248918915;
            5'd2:    v = 31'd131521918;
            5'd3:    v = 31'd66762579;
            5'd4:    v = 31'd33510843;
            5'd5:    v = 31'd16771758;
            5'd6:    v = 31'd8387925;
            5'd7:    v = 31'd4194219;
            5'd8:    v = 31'd2097141;
            5'd9:    v = 31'd1048575;
            5'd10:   v = 31'd524288;
            5'd11:   v = 31'd262144;
            5'd12:   v = 31'd131072;
            5'd13:   v = 31'd65536;
            5'd14:   v = 31'd32768;
            5'd15:   v = 31'd16384;
            5'd16:   v = 31'd8192;
            5'd17:   v = 31'd4096;
            5'd18:   v = 31'd2048;
            5'd19:   v = 31'd1024;
            5'd20:   v = 31'd512;
            5'd21:   v = 31'd256;
            5'd22:   v = 31'd128;
            5'd23:   v = 31'd64;
            5'd24:   v = 31'd32;
            5'd25:   v = 31'd16;
            5'd26:   v = 31'd8;
            5'd27:   v = 31'd4;
            5'd28:   v = 31'd2;
            5'd29:   v = 31'd1;
            default: v = 31'd0;
        endcase
        return $signed({2'b00, v});
    endfunction

endpackage

`default_nettype wire

// ----- sv/lal_sqrt_cell.sv -----
// one digit cell of the pipelined integer square root
`timescale 1ns / 1ps
`default_nettype none

module lal_sqrt_cell import lal_pkg::*; #(
    parameter int BIT_POS = 0
) (
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_sqrt i_st,
    output t_sqrt      o_st
);

    localparam logic [VEC_W-1:0] BIT = VEC_W'(1) << (2 * BIT_POS);

    logic [VEC_W-1:0] trial;
    t_sqrt            n_st;
    t_sqrt            r_st;

    assign trial = i_st.root + BIT;

    always_comb begin
        if (i_st.rem >= trial) begin
            n_st.rem  = i_st.rem - trial;
            n_st.root = (i_st.root >> 1) + BIT;
        end else begin
            n_st.rem  = i_st.rem;
            n_st.root = i_st.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

`default_nettype wire

// ----- sv/lal_cordic_cell.sv -----
// one vectoring stage of the cordic arctangent chain
`timescale 1ns / 1ps
`default_nettype none

module lal_cordic_cell import lal_pkg::*; #(
    parameter int SHIFT = 0
) (
    input  wire logic    i_clk,
    input  wire logic    i_en,
    input  wire t_cordic i_st,
    output t_cordic      o_st
);

    localparam logic signed [Z_W-1:0] ANG = atan_entry(5'(SHIFT));

    logic signed [CX_W-1:0] xs;
    logic signed [CX_W-1:0] ys;
    t_cordic                n_st;
    t_cordic                r_st;

    assign xs = i_st.x >>> SHIFT;
    assign ys = i_st.y >>> SHIFT;

    always_comb begin
        n_st = i_st;
        if (i_st.y[CX_W-1]) begin
            n_st.x = i_st.x - ys;
            n_st.y = i_st.y + xs;
            n_st.z = i_st.z - ANG;
        end else if (i_st.y != '0) begin
            n_st.x = i_st.x + ys;
            n_st.y = i_st.y - xs;
            n_st.z = i_st.z + ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

`default_nettype wire

// ----- sv/lal_atan_unit.sv -----
// pipelined atan2 with prescale, quarter-turn pre-rotation, cordic chain and rounding
`timescale 1ns / 1ps
`default_nettype none

module lal_atan_unit import lal_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic signed [VEC_W-1:0] i_y,
    input  wire logic signed [VEC_W-1:0] i_x,
    output logic signed [ANG_W-1:0]      o_angle
);

    t_smag                   r_sm [PRESCALE_STEPS+1];
    t_smag                   n_sm0;
    t_smag                   sm_last;
    logic signed [PRE_W-1:0] yv;
    logic signed [PRE_W-1:0] xv;
    t_cordic                 n_rot;
    t_cordic                 r_rot;
    t_cordic                 w_c [STAGES+1];
    logic signed [Z_W-1:0]   n_zr;
    logic signed [ANG_W-1:0] r_angle;

    always_comb begin
        n_sm0.sy = i_y[VEC_W-1];
        n_sm0.sx = i_x[VEC_W-1];
        n_sm0.my = i_y[VEC_W-1] ? MAG_W'(-i_y) : MAG_W'(i_y);
        n_sm0.mx = i_x[VEC_W-1] ? MAG_W'(-i_x) : MAG_W'(i_x);
    end

    assign sm_last = r_sm[PRESCALE_STEPS];
    assign yv = sm_last.sy ? -$signed(PRE_W'(sm_last.my)) : $signed(PRE_W'(sm_last.my));
    assign xv = sm_last.sx ? -$signed(PRE_W'(sm_last.mx)) : $signed(PRE_W'(sm_last.mx));

    // quarter-turn pre-rotation into the right half plane
    always_comb begin
        n_rot.x = CX_W'(xv);
        n_rot.y = CX_W'(yv);
        n_rot.z = '0;
        if (xv[PRE_W-1]) begin
            if (!yv[PRE_W-1]) begin
                n_rot.x = CX_W'(yv);
                n_rot.y = -CX_W'(xv);
                n_rot.z = ANG_HALF_PI;
            end else begin
                n_rot.x = -CX_W'(yv);
                n_rot.y = CX_W'(xv);
                n_rot.z = -ANG_HALF_PI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sm[0] <= n_sm0;
            for (int k = 0; k < PRESCALE_STEPS; k++) begin
                if (|(r_sm[k].my[MAG_W-1:PRE_LIMIT_BIT] | r_sm[k].mx[MAG_W-1:PRE_LIMIT_BIT]))
                begin
                    r_sm[k+1].sy <= r_sm[k].sy;
                    r_sm[k+1].sx <= r_sm[k].sx;
                    r_sm[k+1].my <= r_sm[k].my >> 1;
                    r_sm[k+1].mx <= r_sm[k].mx >> 1;
                end else begin
                    r_sm[k+1] <= r_sm[k];
                end
            end
            r_rot   <= n_rot;
            r_angle <= ANG_W'(n_zr >>> ROUND_SH);
        end
    end

    assign w_c[0] = r_rot;

    for (genvar i = 0; i < STAGES; i++) begin : g_cell
        lal_cordic_cell #(
            .SHIFT (i)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_st  (w_c[i]),
            .o_st  (w_c[i+1])
        );
    end

    assign n_zr    = w_c[STAGES].z + $signed(Z_W'(ROUND_HALF));
    assign o_angle = r_angle;

endmodule

`default_nettype wire

// ----- sv/look_at_angle_limiter.sv -----
// top level of the look-at angle limiter: geometry front end, square root and atan2 pipelines
//
//  channel   direction  handshake                   payload
//  in        sink       i_in_valid / o_in_ready     i_neck_off_*, i_char_*, i_fwd_*, i_target_*
//  out       source     o_out_valid / i_out_ready   o_pitch_angle, o_yaw_angle, o_zeroed
//  cfg       sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
//  one beat per cycle while the pipe advances; from accept to o_out_valid a beat passes the
//  front end stages, the 31 square root cells, the 31 prescale steps and the cordic chain
//  the whole pipe advances together; it keeps moving while the output register holds a
//  beat as long as the last stage is empty, and stops only when both are full
//  synchronous active-low reset clears the valid bits and the output valid and sets the limits to LIMIT_RST
//  cfg writes are taken every cycle
`timescale 1ns / 1ps
`default_nettype none

module look_at_angle_limiter import lal_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic signed [IN_W-1:0] i_neck_off_x,
    input  wire logic signed [IN_W-1:0] i_neck_off_y,
    input  wire logic signed [IN_W-1:0] i_neck_off_z,
    input  wire logic signed [IN_W-1:0] i_char_x,
    input  wire logic signed [IN_W-1:0] i_char_y,
    input  wire logic signed [IN_W-1:0] i_char_z,
    input  wire logic signed [IN_W-1:0] i_fwd_x,
    input  wire logic signed [IN_W-1:0] i_fwd_z,
    input  wire logic signed [IN_W-1:0] i_target_x,
    input  wire logic signed [IN_W-1:0] i_target_y,
    input  wire logic signed [IN_W-1:0] i_target_z,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic signed [ANG_W-1:0]     o_pitch_angle,
    output logic signed [ANG_W-1:0]     o_yaw_angle,
    output logic                        o_zeroed,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int ATAN_LAT = PRESCALE_STEPS + 3 + CORDIC_STAGES;
    localparam int TAIL     = SQRT_CELLS + 1 + ATAN_LAT;
    localparam int D_W      = IN_W + 2;
    localparam int G_W      = IN_W + 1;
    localparam int PRESH_W  = 3;

    typedef struct packed {
        logic vld;
        logic degen;
        logic special;
    } t_side;

    function automatic logic [D_W-1:0] mag_of(input logic signed [D_W-1:0] v);
        return v[D_W-1] ? D_W'(-v) : D_W'(v);
    endfunction

    function automatic logic [PRESH_W-1:0] pre_shift(input logic [D_W-1:0] m);
        logic [PRESH_W-1:0] s;
        priority if (m[PRE_LIMIT_BIT+3]) s = 3'd4;
        else if (m[PRE_LIMIT_BIT+2])     s = 3'd3;
        else if (m[PRE_LIMIT_BIT+1])     s = 3'd2;
        else if (m[PRE_LIMIT_BIT])       s = 3'd1;
        else                             s = 3'd0;
        return s;
    endfunction

    function automatic logic signed [PRE_W-1:0] pre_apply(
        input logic signed [D_W-1:0] v,
        input logic [PRESH_W-1:0]    s
    );
        logic [D_W-1:0]   m;
        logic [PRE_W-1:0] t;
        m = mag_of(v) >> s;
        t = PRE_W'(m);
        return v[D_W-1] ? -$signed(t) : $signed(t);
    endfunction

    logic en;
    logic v_last;

    logic [LIM_W-1:0] r_pitch_limit;
    logic [LIM_W-1:0] r_yaw_limit;

    // stage a: differences
    logic signed [D_W-1:0] n_d0, n_d1, n_d2;
    logic signed [G_W-1:0] n_g0, n_g1;
    logic                  n_degen;
    t_side                 r_side_a;
    logic signed [D_W-1:0] r_d0, r_d1, r_d2;
    logic signed [IN_W-1:0] r_f0, r_f1;
    logic signed [G_W-1:0] r_g0, r_g1;

    // stage b: prescale
    logic [PRESH_W-1:0]      s_d, s_f, s_g;
    t_side                   r_side_b;
    logic signed [PRE_W-1:0] r_pd0, r_pd1, r_pd2, r_pf0, r_pf1, r_pg0, r_pg1;

    // stage c: products
    logic signed [VEC_W-1:0] n_sq0, n_sq2, n_pa, n_pb, n_pc, n_pe;
    t_side                   r_side_c;
    logic signed [VEC_W-1:0] r_sq0, r_sq2, r_pa, r_pb, r_pc, r_pe;
    logic signed [PRE_W-1:0] r_d1_c;

    // stage d: sums
    logic signed [VEC_W-1:0] n_h2, n_cross, n_dot;
    logic                    n_special;
    logic signed [VEC_W-1:0] r_h2, r_cross, r_dot;
    logic signed [PRE_W-1:0] r_d1_d;

    t_side                   r_tail [TAIL];
    logic signed [PRE_W-1:0] r_dl_d1    [SQRT_CELLS];
    logic signed [VEC_W-1:0] r_dl_cross [SQRT_CELLS];
    logic signed [VEC_W-1:0] r_dl_dot   [SQRT_CELLS];
    t_sqrt                   w_sq [SQRT_CELLS+1];

    logic signed [ANG_W-1:0] p_ang, y_ang, n_pitch, n_yaw;
    logic [ANG_W-1:0]        p_abs, y_abs;
    logic                    n_limited;
    t_side                   side_last;

    logic                    r_out_valid;
    logic signed [ANG_W-1:0] r_pitch, r_yaw;
    logic                    r_zeroed;

    assign side_last = r_tail[TAIL-1];
    assign v_last    = side_last.vld;
    assign en        = !r_out_valid || i_out_ready || !v_last;

    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_limit <= LIMIT_RST;
            r_yaw_limit   <= LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PITCH_LIMIT: r_pitch_limit <= i_cfg_data[LIM_W-1:0];
                CFG_YAW_LIMIT:   r_yaw_limit   <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign n_d0 = D_W'(i_target_x) - (D_W'(i_char_x) + D_W'(i_neck_off_x));
    assign n_d1 = D_W'(i_target_y) - (D_W'(i_char_y) + D_W'(i_neck_off_y));
    assign n_d2 = D_W'(i_target_z) - (D_W'(i_char_z) + D_W'(i_neck_off_z));
    assign n_g0 = G_W'(i_target_x) - G_W'(i_char_x);
    assign n_g1 = G_W'(i_target_z) - G_W'(i_char_z);
    assign n_degen = (n_d0 == '0 && n_d1 == '0 && n_d2 == '0) ||
                     (i_fwd_x == '0 && i_fwd_z == '0) ||
                     (n_g0 == '0 && n_g1 == '0);

    assign s_d = pre_shift(mag_of(r_d0) | mag_of(r_d1) | mag_of(r_d2));
    assign s_f = pre_shift(mag_of(D_W'(r_f0)) | mag_of(D_W'(r_f1)));
    assign s_g = pre_shift(mag_of(D_W'(r_g0)) | mag_of(D_W'(r_g1)));

    assign n_sq0 = r_pd0 * r_pd0;
    assign n_sq2 = r_pd2 * r_pd2;
    assign n_pa  = r_pf0 * r_pg1;
    assign n_pb  = r_pf1 * r_pg0;
    assign n_pc  = r_pf0 * r_pg0;
    assign n_pe  = r_pf1 * r_pg1;

    assign n_h2      = r_sq0 + r_sq2;
    assign n_cross   = r_pa - r_pb;
    assign n_dot     = r_pc + r_pe;
    assign n_special = (n_cross == '0) && n_dot[VEC_W-1];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_a <= '0;
            r_side_b <= '0;
            r_side_c <= '0;
            for (int k = 0; k < TAIL; k++) begin
                r_tail[k] <= '0;
            end
        end else if (en) begin
            r_side_a <= '{vld: i_in_valid, degen: n_degen, special: 1'b0};
            r_side_b <= r_side_a;
            r_side_c <= r_side_b;
            r_tail[0] <= '{vld: r_side_c.vld, degen: r_side_c.degen, special: n_special};
            for (int k = 1; k < TAIL; k++) begin
                r_tail[k] <= r_tail[k-1];
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d0 <= n_d0;
            r_d1 <= n_d1;
            r_d2 <= n_d2;
            r_f0 <= i_fwd_x;
            r_f1 <= i_fwd_z;
            r_g0 <= n_g0;
            r_g1 <= n_g1;

            r_pd0 <= pre_apply(r_d0, s_d);
            r_pd1 <= pre_apply(r_d1, s_d);
            r_pd2 <= pre_apply(r_d2, s_d);
            r_pf0 <= pre_apply(D_W'(r_f0), s_f);
            r_pf1 <= pre_apply(D_W'(r_f1), s_f);
            r_pg0 <= pre_apply(D_W'(r_g0), s_g);
            r_pg1 <= pre_apply(D_W'(r_g1), s_g);

            r_sq0  <= n_sq0;
            r_sq2  <= n_sq2;
            r_pa   <= n_pa;
            r_pb   <= n_pb;
            r_pc   <= n_pc;
            r_pe   <= n_pe;
            r_d1_c <= r_pd1;

            r_h2    <= n_h2;
            r_cross <= n_cross;
            r_dot   <= n_dot;
            r_d1_d  <= r_d1_c;

            r_dl_d1[0]    <= r_d1_d;
            r_dl_cross[0] <= r_cross;
            r_dl_dot[0]   <= r_dot;
            for (int k = 1; k < SQRT_CELLS; k++) begin
                r_dl_d1[k]    <= r_dl_d1[k-1];
                r_dl_cross[k] <= r_dl_cross[k-1];
                r_dl_dot[k]   <= r_dl_dot[k-1];
            end
        end
    end

    assign w_sq[0] = '{rem: r_h2, root: '0};

    for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
        lal_sqrt_cell #(
            .BIT_POS (SQRT_CELLS - 1 - k)
        ) u_sqrt (
            .i_clk (i_clk),
            .i_en  (en),
            .i_st  (w_sq[k]),
            .o_st  (w_sq[k+1])
        );
    end

    lal_atan_unit #(
        .STAGES (CORDIC_STAGES)
    ) u_atan_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (VEC_W'(r_dl_d1[SQRT_CELLS-1])),
        .i_x     ($signed(w_sq[SQRT_CELLS].root)),
        .o_angle (p_ang)
    );

    lal_atan_unit #(
        .STAGES (CORDIC_STAGES)
    ) u_atan_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_dl_cross[SQRT_CELLS-1]),
        .i_x     (r_dl_dot[SQRT_CELLS-1]),
        .o_angle (y_ang)
    );

    assign n_pitch   = -p_ang;
    assign n_yaw     = side_last.special ? -Q13_PI : -y_ang;
    assign p_abs     = n_pitch[ANG_W-1] ? ANG_W'(-n_pitch) : ANG_W'(n_pitch);
    assign y_abs     = n_yaw[ANG_W-1] ? ANG_W'(-n_yaw) : ANG_W'(n_yaw);
    assign n_limited = (p_abs > {1'b0, r_pitch_limit}) || (y_abs > {1'b0, r_yaw_limit});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && v_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && v_last) begin
            if (side_last.degen || n_limited) begin
                r_pitch  <= '0;
                r_yaw    <= '0;
                r_zeroed <= 1'b1;
            end else begin
                r_pitch  <= n_pitch;
                r_yaw    <= n_yaw;
                r_zeroed <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pitch_angle = r_pitch;
    assign o_yaw_angle   = r_yaw;
    assign o_zeroed      = r_zeroed;

endmodule

`default_nettype wire

// ----- sv/lal_checker.sv -----
// port-level checks of the look-at angle limiter and their bind
`timescale 1ns / 1ps
`default_nettype none

module lal_checker import lal_pkg::*; (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    o_in_ready,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_ready,
    input wire logic signed [ANG_W-1:0] o_pitch_angle,
    input wire logic signed [ANG_W-1:0] o_yaw_angle,
    input wire logic                    o_zeroed
);

    // a stalled out beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pitch_angle) &&
        $stable(o_yaw_angle) && $stable(o_zeroed))
        else $error("out beat changed while stalled");

    a_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zeroed |-> o_pitch_angle == '0 && o_yaw_angle == '0)
        else $error("zeroed beat with nonzero angle");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_zeroed |-> o_yaw_angle >= -Q13_PI && o_yaw_angle <= Q13_PI &&
        o_pitch_angle >= -Q13_PI && o_pitch_angle <= Q13_PI)
        else $error("angle beyond half turn");

    // input back-pressure only comes from a full, stalled output
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("in not ready without output stall");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("out valid right after reset");

endmodule

bind look_at_angle_limiter lal_checker u_lal_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pitch_angle (o_pitch_angle),
    .o_yaw_angle   (o_yaw_angle),
    .o_zeroed      (o_zeroed)
);

`default_nettype wire
